### sv/stt_pkg.sv
// Shared types, codes and character helpers for the source text tokenizer.
`timescale 1ns / 1ps

package stt_pkg;

    // Record kinds on the result channel.
    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_EOS  = 2'd2;

    // Token types reported in end records.
    localparam logic [2:0] TYPE_KEYWORD = 3'd0;
    localparam logic [2:0] TYPE_IDENT   = 3'd1;
    localparam logic [2:0] TYPE_NUMBER  = 3'd2;
    localparam logic [2:0] TYPE_STRING  = 3'd3;
    localparam logic [2:0] TYPE_OPER    = 3'd4;
    localparam logic [2:0] TYPE_PUNCT   = 3'd5;
    localparam logic [2:0] TYPE_UNKNOWN = 3'd6;

    // Keyword number for tokens that are not keywords.
    localparam logic [3:0] NO_KEYWORD = 4'd8;

    // Scanner modes.
    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_STRING  = 3'd1;
    localparam logic [2:0] MODE_NUMBER  = 3'd2;
    localparam logic [2:0] MODE_IDENT   = 3'd3;
    localparam logic [2:0] MODE_OPER    = 3'd4;
    localparam logic [2:0] MODE_STOPPED = 3'd5;

    // Characters with a meaning of their own.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_EQ    = 8'h3D;

    // Most records that one item can cause.
    localparam int MAX_RECORDS = 4;

    // Keywords, left-aligned with the first character in the top byte.
    localparam logic [63:0] KW_WORDS [8] = '{
        {"tam",     40'h0},
        {"kesir",   24'h0},
        {"metin",   24'h0},
        {"yazdir",  16'h0},
        {"oku",     40'h0},
        {"eger",    32'h0},
        {"degilse",  8'h0},
        {"dongu",   24'h0}
    };
    localparam logic [2:0] KW_LEN [8] = '{
        3'd3, 3'd5, 3'd5, 3'd6, 3'd3, 3'd4, 3'd7, 3'd5
    };

    // One result record; last_of_run is added on the way out.
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  tbyte;
        logic [2:0]  token_type;
        logic [3:0]  keyword_number;
        logic [15:0] token_length;
    } stt_rec_t;

    // All records caused by one item, in order.
    typedef struct packed {
        logic [2:0]                     count;
        stt_rec_t [MAX_RECORDS-1:0]     recs;
    } stt_group_t;

    // An optional token end record.
    typedef struct packed {
        logic     valid;
        stt_rec_t rec;
    } stt_end_t;

    function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] i);
        logic [63:0] w;
        w = KW_WORDS[k];
        return w[{3'd7 - i, 3'd0} +: 8];
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
    endfunction

    // Operators that may take a trailing '='.
    function automatic logic is_oper2(input logic [7:0] b);
        return (b == 8'h3D) || (b == 8'h21) || (b == 8'h3C) || (b == 8'h3E);
    endfunction

    // Single-byte operators.
    function automatic logic is_oper1(input logic [7:0] b);
        return (b == 8'h2B) || (b == 8'h2D) || (b == 8'h2A) || (b == 8'h2F);
    endfunction

    function automatic logic is_punct(input logic [7:0] b);
        return (b == 8'h3B) || (b == 8'h7B) || (b == 8'h7D) || (b == 8'h28)
            || (b == 8'h29);
    endfunction

    function automatic stt_rec_t byte_rec(input logic [7:0] b);
        stt_rec_t r;
        r = '0;
        r.kind  = KIND_BYTE;
        r.tbyte = b;
        return r;
    endfunction

    function automatic stt_rec_t short_end_rec(input logic [2:0] t);
        stt_rec_t r;
        r = '0;
        r.kind           = KIND_END;
        r.token_type     = t;
        r.keyword_number = NO_KEYWORD;
        r.token_length   = 16'd1;
        return r;
    endfunction

    function automatic stt_rec_t eos_rec();
        stt_rec_t r;
        r = '0;
        r.kind = KIND_EOS;
        return r;
    endfunction

endpackage

### sv/stt_src_if.sv
// Channel that carries source text bytes into the tokenizer.
`timescale 1ns / 1ps

interface stt_src_if;
    logic       valid;
    logic       ready;
    logic [7:0] source_byte;
    logic       end_of_source;

    modport source (output valid, output source_byte, output end_of_source, input ready);
    modport sink   (input valid, input source_byte, input end_of_source, output ready);
endinterface

### sv/stt_rec_if.sv
// Channel that carries token records out of the tokenizer.
`timescale 1ns / 1ps

interface stt_rec_if;
    logic        valid;
    logic        ready;
    logic [1:0]  record_kind;
    logic [7:0]  token_byte;
    logic [2:0]  token_type;
    logic [3:0]  keyword_number;
    logic [15:0] token_length;
    logic        last_of_run;

    modport source (output valid, output record_kind, output token_byte, output token_type,
                    output keyword_number, output token_length, output last_of_run,
                    input ready);
    modport sink   (input valid, input record_kind, input token_byte, input token_type,
                    input keyword_number, input token_length, input last_of_run,
                    output ready);
endinterface

### sv/source_text_tokenizer.sv
// Top level of the streaming source text tokenizer.
`timescale 1ns / 1ps

// Takes one source byte per item and streams token records: each token byte
// as it arrives, then an end record with type, keyword number and length.
// A byte is registered, classified combinationally against the scanner state
// and its records are loaded into the result register together. Records leave
// one a cycle while the receiver is ready, so a byte inside a token or
// whitespace goes at one byte per cycle, while a byte that closes one token and
// opens another causes two to four records. The result register takes the next
// item's records as the last one of the previous item leaves. Token lengths
// saturate at 2^LENGTH_BITS-1 and are reported capped at 65535.
module source_text_tokenizer #(
    parameter int LENGTH_BITS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    stt_src_if.sink   text,
    stt_rec_if.source tokens
);
    import stt_pkg::*;

    logic       can_load;
    logic       push;
    stt_group_t group;

    stt_lexer_core #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .text     (text),
        .can_load (can_load),
        .push     (push),
        .group    (group)
    );

    stt_record_serializer u_ser (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .group    (group),
        .can_load (can_load),
        .tokens   (tokens)
    );

endmodule

### sv/stt_lexer_core.sv
// Input register, scanner state and the per-byte record builder.
`timescale 1ns / 1ps

module stt_lexer_core #(
    parameter int LENGTH_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    stt_src_if.sink            text,
    input  logic               can_load,
    output logic               push,
    output stt_pkg::stt_group_t group
);
    import stt_pkg::*;

    localparam logic [LENGTH_BITS-1:0] CNT_MAX = '1;

    // Input register.
    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic                   in_eos_reg;

    // Scanner state.
    logic [2:0]             mode_reg;
    logic [2:0]             mode_next;
    logic [7:0]             mask_reg;
    logic [7:0]             mask_next;
    logic [LENGTH_BITS-1:0] cnt_reg;
    logic [LENGTH_BITS-1:0] cnt_next;

    logic [2:0]             n_v;
    stt_rec_t [MAX_RECORDS-1:0] recs_v;
    logic                   start_v;
    stt_end_t               ender;
    logic                   advance;
    logic [7:0]             b;

    // Length saturates at the counter maximum and again at 16 bits.
    function automatic logic [15:0] report_len(input logic [LENGTH_BITS-1:0] c);
        logic [31:0] w;
        w = 32'(c);
        return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
    endfunction

    function automatic logic [LENGTH_BITS-1:0] bump(input logic [LENGTH_BITS-1:0] c);
        return (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

    // Drop each keyword whose character at this position differs.
    function automatic logic [7:0] match_mask(input logic [7:0] mask,
                                              input logic [LENGTH_BITS-1:0] c,
                                              input logic [7:0] ch);
        logic [7:0] m;
        m = mask;
        for (int k = 0; k < 8; k++) begin
            if (!((c < LENGTH_BITS'(KW_LEN[k])) && (kw_char(3'(k), c[2:0]) == ch))) begin
                m[k] = 1'b0;
            end
        end
        return m;
    endfunction

    // End record for the token open in the given mode, if any.
    function automatic stt_end_t end_rec(input logic [2:0] mode,
                                         input logic [7:0] mask,
                                         input logic [LENGTH_BITS-1:0] c);
        stt_end_t e;
        logic     found;
        e     = '0;
        found = 1'b0;
        e.rec.kind           = KIND_END;
        e.rec.keyword_number = NO_KEYWORD;
        e.rec.token_length   = report_len(c);
        case (mode)
            MODE_STRING:
            begin
                e.valid          = 1'b1;
                e.rec.token_type = TYPE_STRING;
            end
            MODE_NUMBER:
            begin
                e.valid          = 1'b1;
                e.rec.token_type = TYPE_NUMBER;
            end
            MODE_OPER:
            begin
                e.valid          = 1'b1;
                e.rec.token_type = TYPE_OPER;
            end
            MODE_IDENT:
            begin
                e.valid          = 1'b1;
                e.rec.token_type = TYPE_IDENT;
                for (int k = 0; k < 8; k++) begin
                    if (!found && mask[k] && (c == LENGTH_BITS'(KW_LEN[k]))) begin
                        found                = 1'b1;
                        e.rec.token_type     = TYPE_KEYWORD;
                        e.rec.keyword_number = 4'(k);
                    end
                end
            end
            default:
            begin
                e.valid = 1'b0;
            end
        endcase
        return e;
    endfunction

    assign b = in_byte_reg;

    // Build the records for the registered byte and the next scanner state.
    always_comb
    begin
        mode_next = mode_reg;
        mask_next = mask_reg;
        cnt_next  = cnt_reg;
        n_v       = 3'd0;
        recs_v    = '0;
        start_v   = 1'b0;
        ender     = '0;

        // Continue or close the open token.
        case (mode_reg)
            MODE_STRING:
            begin
                if ((b == CH_QUOTE) || (b == CH_NUL))
                begin
                    ender = end_rec(mode_next, mask_next, cnt_next);
                    recs_v[n_v[1:0]] = ender.rec;
                    n_v = n_v + 3'd1;
                    mode_next = MODE_IDLE;
                end
                else
                begin
                    recs_v[n_v[1:0]] = byte_rec(b);
                    n_v = n_v + 3'd1;
                    cnt_next = bump(cnt_next);
                end
            end
            MODE_NUMBER:
            begin
                if (is_digit(b) || (b == CH_DOT))
                begin
                    recs_v[n_v[1:0]] = byte_rec(b);
                    n_v = n_v + 3'd1;
                    cnt_next = bump(cnt_next);
                end
                else
                begin
                    ender = end_rec(mode_next, mask_next, cnt_next);
                    recs_v[n_v[1:0]] = ender.rec;
                    n_v = n_v + 3'd1;
                    mode_next = MODE_IDLE;
                    start_v = 1'b1;
                end
            end
            MODE_IDENT:
            begin
                if (is_alpha(b) || is_digit(b))
                begin
                    mask_next = match_mask(mask_next, cnt_next, b);
                    recs_v[n_v[1:0]] = byte_rec(b);
                    n_v = n_v + 3'd1;
                    cnt_next = bump(cnt_next);
                end
                else
                begin
                    ender = end_rec(mode_next, mask_next, cnt_next);
                    recs_v[n_v[1:0]] = ender.rec;
                    n_v = n_v + 3'd1;
                    mode_next = MODE_IDLE;
                    start_v = 1'b1;
                end
            end
            MODE_OPER:
            begin
                if (b == CH_EQ)
                begin
                    recs_v[n_v[1:0]] = byte_rec(b);
                    n_v = n_v + 3'd1;
                    cnt_next = bump(cnt_next);
                    ender = end_rec(mode_next, mask_next, cnt_next);
                    recs_v[n_v[1:0]] = ender.rec;
                    n_v = n_v + 3'd1;
                    mode_next = MODE_IDLE;
                end
                else
                begin
                    ender = end_rec(mode_next, mask_next, cnt_next);
                    recs_v[n_v[1:0]] = ender.rec;
                    n_v = n_v + 3'd1;
                    mode_next = MODE_IDLE;
                    start_v = 1'b1;
                end
            end
            MODE_STOPPED:
            begin
                start_v = 1'b0;
            end
            default:
            begin
                mode_next = MODE_IDLE;
                start_v   = 1'b1;
            end
        endcase

        // Open a new token with this byte.
        if (start_v)
        begin
            cnt_next = '0;
            if (is_space(b))
            begin
                mode_next = MODE_IDLE;
            end
            else if (b == CH_NUL)
            begin
                recs_v[n_v[1:0]] = eos_rec();
                n_v = n_v + 3'd1;
                mode_next = MODE_STOPPED;
            end
            else if (b == CH_QUOTE)
            begin
                mode_next = MODE_STRING;
            end
            else if (is_digit(b))
            begin
                mode_next = MODE_NUMBER;
                recs_v[n_v[1:0]] = byte_rec(b);
                n_v = n_v + 3'd1;
                cnt_next = bump(cnt_next);
            end
            else if (is_alpha(b))
            begin
                mode_next = MODE_IDENT;
                mask_next = match_mask(8'hFF, cnt_next, b);
                recs_v[n_v[1:0]] = byte_rec(b);
                n_v = n_v + 3'd1;
                cnt_next = bump(cnt_next);
            end
            else if (is_oper2(b))
            begin
                mode_next = MODE_OPER;
                recs_v[n_v[1:0]] = byte_rec(b);
                n_v = n_v + 3'd1;
                cnt_next = bump(cnt_next);
            end
            else
            begin
                recs_v[n_v[1:0]] = byte_rec(b);
                n_v = n_v + 3'd1;
                if (is_oper1(b))
                begin
                    recs_v[n_v[1:0]] = short_end_rec(TYPE_OPER);
                end
                else if (is_punct(b))
                begin
                    recs_v[n_v[1:0]] = short_end_rec(TYPE_PUNCT);
                end
                else
                begin
                    recs_v[n_v[1:0]] = short_end_rec(TYPE_UNKNOWN);
                end
                n_v = n_v + 3'd1;
            end
        end

        // The final byte flushes the open token and ends the stream.
        if (in_eos_reg)
        begin
            if (mode_next != MODE_STOPPED)
            begin
                ender = end_rec(mode_next, mask_next, cnt_next);
                if (ender.valid)
                begin
                    recs_v[n_v[1:0]] = ender.rec;
                    n_v = n_v + 3'd1;
                end
                recs_v[n_v[1:0]] = eos_rec();
                n_v = n_v + 3'd1;
            end
            mode_next = MODE_IDLE;
            cnt_next  = '0;
        end
    end

    // An item moves on when it leaves no records or the output stage can take them.
    assign advance     = in_valid_reg && ((n_v == 3'd0) || can_load);
    assign push        = advance && (n_v != 3'd0);
    assign group.count = n_v;
    assign group.recs  = recs_v;
    assign text.ready  = !in_valid_reg || advance;

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (text.valid && text.ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (text.valid && text.ready)
        begin
            in_byte_reg <= text.source_byte;
            in_eos_reg  <= text.end_of_source;
        end
    end

    // Scanner state update.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            mask_reg <= 8'hFF;
            cnt_reg  <= '0;
        end
        else if (advance)
        begin
            mode_reg <= mode_next;
            mask_reg <= mask_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

### sv/stt_record_serializer.sv
// Result register that holds one item's records and hands them out one a cycle while the receiver is ready.
`timescale 1ns / 1ps

module stt_record_serializer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  stt_pkg::stt_group_t group,
    output logic                can_load,
    stt_rec_if.source           tokens
);
    import stt_pkg::*;

    logic       full_reg;
    stt_group_t grp_reg;
    logic [1:0] pos_reg;
    logic       last;
    logic       pop;
    stt_rec_t   cur;

    // Record on show and whether it closes the run.
    assign cur      = grp_reg.recs[pos_reg];
    assign last     = ((3'(pos_reg) + 3'd1) == grp_reg.count);
    assign pop      = full_reg && tokens.ready;
    assign can_load = !full_reg || (pop && last);

    assign tokens.valid          = full_reg;
    assign tokens.record_kind    = cur.kind;
    assign tokens.token_byte     = cur.tbyte;
    assign tokens.token_type     = cur.token_type;
    assign tokens.keyword_number = cur.keyword_number;
    assign tokens.token_length   = cur.token_length;
    assign tokens.last_of_run    = last;

    // Occupancy and read position.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
            pos_reg  <= 2'd0;
        end
        else if (push)
        begin
            full_reg <= 1'b1;
            pos_reg  <= 2'd0;
        end
        else if (pop)
        begin
            if (last)
            begin
                full_reg <= 1'b0;
                pos_reg  <= 2'd0;
            end
            else
            begin
                pos_reg <= pos_reg + 2'd1;
            end
        end
    end

    // Record group payload.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            grp_reg <= group;
        end
    end

    // The read position stays inside the held group.
    a_pos_in_group: assert property (@(posedge clk) disable iff (!rst_n)
        full_reg |-> (3'(pos_reg) < grp_reg.count))
        else $error("read position beyond held records");

    // A loaded group is shown from its first record.
    a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> (full_reg && (pos_reg == 2'd0)))
        else $error("loaded group not shown from its first record");

    // End of stream always closes the run of records.
    a_eos_last: assert property (@(posedge clk) disable iff (!rst_n)
        (full_reg && (cur.kind == KIND_EOS)) |-> last)
        else $error("end of stream record is not the last of its run");

    // A new group is only loaded when the previous one is done.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> can_load)
        else $error("group loaded over unfinished records");

endmodule
